### rtl/piet_stack_command_unit_top_assert.svh
// Assertion macros for the Piet stack command unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef PIET_STACK_COMMAND_UNIT_TOP_ASSERT_SVH
`define PIET_STACK_COMMAND_UNIT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// The property holds at every clock edge outside reset.
`define PSCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The condition never holds outside reset.
`define PSCU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PSCU_ASSERT(lbl, prop, msg)
`define PSCU_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/pscu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piet stack command unit package
// Beat types, command codes, result codes and colour decoding.
// ----------------------------------------------------------------------------
package pscu_pkg;

  typedef struct packed {
    logic [4:0]         prev_colour;
    logic [4:0]         new_colour;
    logic [20:0]        block_size;
    logic signed [31:0] in_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic signed [31:0] out_value;
    logic [1:0]         pointer_dir;
    logic               edge_choice;
    logic [6:0]         stack_count;
    logic [1:0]         fault;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE     = 5'd0,
    CMD_PUSH     = 5'd1,
    CMD_POP      = 5'd2,
    CMD_ADD      = 5'd3,
    CMD_SUB      = 5'd4,
    CMD_MUL      = 5'd5,
    CMD_DIV      = 5'd6,
    CMD_MOD      = 5'd7,
    CMD_NOT      = 5'd8,
    CMD_GREATER  = 5'd9,
    CMD_POINTER  = 5'd10,
    CMD_SWITCH   = 5'd11,
    CMD_DUP      = 5'd12,
    CMD_ROLL     = 5'd13,
    CMD_IN_NUM   = 5'd14,
    CMD_IN_CHAR  = 5'd15,
    CMD_OUT_NUM  = 5'd16,
    CMD_OUT_CHAR = 5'd17
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_EXEC,
    ST_DIV,
    ST_DIV_END,
    ST_RV_CHECK,
    ST_SW_RD_LO,
    ST_SW_RD_HI,
    ST_SW_WR_LO,
    ST_SW_WR_HI,
    ST_DONE
  } st_e;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV0 = 2'd1;
  localparam logic [1:0] FAULT_OVF  = 2'd2;

  // Colours above the palette decode as hue 0, lightness 0.
  function automatic logic [2:0] colour_hue(input logic [4:0] c);
    logic [2:0] h;
    case (c)
      5'd1, 5'd7, 5'd13:  h = 3'd1;
      5'd2, 5'd8, 5'd14:  h = 3'd2;
      5'd3, 5'd9, 5'd15:  h = 3'd3;
      5'd4, 5'd10, 5'd16: h = 3'd4;
      5'd5, 5'd11, 5'd17: h = 3'd5;
      default:            h = 3'd0;
    endcase
    return h;
  endfunction

  function automatic logic [1:0] colour_light(input logic [4:0] c);
    logic [1:0] l;
    if (c >= 5'd6 && c <= 5'd11) begin
      l = 2'd1;
    end else if (c >= 5'd12 && c <= 5'd17) begin
      l = 2'd2;
    end else begin
      l = 2'd0;
    end
    return l;
  endfunction

  function automatic cmd_e decode_cmd(input logic [4:0] prev_c, input logic [4:0] new_c);
    logic [2:0] oh;
    logic [2:0] nh;
    logic [1:0] ol;
    logic [1:0] nl;
    logic [2:0] dh;
    logic [1:0] dl;
    oh = colour_hue(prev_c);
    nh = colour_hue(new_c);
    ol = colour_light(prev_c);
    nl = colour_light(new_c);
    dh = (nh >= oh) ? (nh - oh) : (nh + 3'd6 - oh);
    dl = (nl >= ol) ? (nl - ol) : (nl + 2'd3 - ol);
    return cmd_e'(5'({2'b00, dh} * 5'd3) + 5'({3'b000, dl}));
  endfunction

endpackage

### rtl/piet_stack_command_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piet stack command unit
// Executes one colour transition of a Piet interpreter on a value stack.
// ----------------------------------------------------------------------------
// Each input beat is one colour transition and yields exactly one result beat.
// The stack lives in a single-port-read RAM; every command first fetches the
// top two entries, then executes. Divide and remainder run a one-bit-per-cycle
// divider. Roll takes the divider for count mod depth and then rotates the
// entries in place by three reversals, reading and writing back both entries
// of each swap with a range check per swap. A new item is taken once the
// previous one has been handed to the output register.
module piet_stack_command_unit_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pscu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pscu_pkg::out_t out_data_o
);

  import pscu_pkg::*;

  `include "piet_stack_command_unit_top_assert.svh"

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(STACK_DEPTH);
  localparam logic [CNTW-1:0] ONE_C   = CNTW'(1);
  localparam logic [CNTW-1:0] TWO_C   = CNTW'(2);

  st_e             state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [CNTW-1:0] top_q, top_d;
  logic [1:0]      dir_q, dir_d;
  logic            edge_q, edge_d;
  logic [1:0]      kind_q, kind_d;
  logic [31:0]     oval_q, oval_d;
  logic [1:0]      fault_q, fault_d;
  logic [20:0]     bsize_q, bsize_d;
  logic [31:0]     inval_q, inval_d;
  logic [31:0]     a_q, a_d;
  logic [31:0]     b_q, b_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  // Divider and roll bookkeeping.
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [31:0]     dvs_q, dvs_d;
  logic [4:0]      dcnt_q, dcnt_d;
  logic            roll_q, roll_d;
  logic [CNTW-1:0] base_q, base_d;
  logic [CNTW-1:0] len_q, len_d;
  logic [CNTW-1:0] k_q, k_d;
  logic [1:0]      phase_q, phase_d;
  logic [CNTW-1:0] lo_q, lo_d;
  logic [CNTW-1:0] hi_q, hi_d;
  logic [31:0]     swap_q, swap_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  logic [CNTW-1:0] top_m1, top_m2, hi_m1;
  logic [32:0]     rem_sh;
  logic [31:0]     quo_sh;
  logic            in_accept;
  logic            div_neg;
  logic [31:0]     q_signed, r_signed;
  logic [31:0]     mag_a, mag_b;
  logic [CNTW-1:0] roll_len;

  pscu_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign top_m1   = top_q - ONE_C;
  assign top_m2   = top_q - TWO_C;
  assign hi_m1    = hi_q - ONE_C;
  assign rem_sh   = {rem_q, quo_q[31]};
  assign quo_sh   = {quo_q[30:0], 1'b0};
  assign mag_a    = a_q[31] ? (32'd0 - a_q) : a_q;
  assign mag_b    = b_q[31] ? (32'd0 - b_q) : b_q;
  assign div_neg  = a_q[31] ^ b_q[31];
  assign q_signed = div_neg ? (32'd0 - quo_q) : quo_q;
  assign r_signed = b_q[31] ? (32'd0 - rem_q) : rem_q;
  assign roll_len = b_q[CNTW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      dir_q       <= '0;
      edge_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      dir_q       <= dir_d;
      edge_q      <= edge_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    kind_q  <= kind_d;
    oval_q  <= oval_d;
    fault_q <= fault_d;
    bsize_q <= bsize_d;
    inval_q <= inval_d;
    a_q     <= a_d;
    b_q     <= b_d;
    out_q   <= out_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvs_q   <= dvs_d;
    dcnt_q  <= dcnt_d;
    roll_q  <= roll_d;
    base_q  <= base_d;
    len_q   <= len_d;
    k_q     <= k_d;
    phase_q <= phase_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    swap_q  <= swap_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    top_d       = top_q;
    dir_d       = dir_q;
    edge_d      = edge_q;
    kind_d      = kind_q;
    oval_d      = oval_q;
    fault_d     = fault_q;
    bsize_d     = bsize_q;
    inval_d     = inval_q;
    a_d         = a_q;
    b_d         = b_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    dcnt_d      = dcnt_q;
    roll_d      = roll_q;
    base_d      = base_q;
    len_d       = len_q;
    k_d         = k_q;
    phase_d     = phase_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    swap_d      = swap_q;
    ram_we      = 1'b0;
    ram_waddr   = top_q[AW-1:0];
    ram_wdata   = 32'd0;
    ram_raddr   = top_m1[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d   = decode_cmd(in_data_i.prev_colour, in_data_i.new_colour);
          bsize_d = in_data_i.block_size;
          inval_d = in_data_i.in_value;
          kind_d  = KIND_NONE;
          oval_d  = 32'd0;
          fault_d = FAULT_NONE;
          roll_d  = 1'b0;
          state_d = ST_FETCH_A;
        end
      end

      ST_FETCH_A: begin
        // Top entry arrives; the second one is requested now.
        a_d       = ram_rdata;
        ram_raddr = top_m2[AW-1:0];
        state_d   = ST_FETCH_B;
      end

      ST_FETCH_B: begin
        b_d     = ram_rdata;
        state_d = ST_EXEC;
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        case (cmd_q)
          CMD_PUSH, CMD_IN_NUM, CMD_IN_CHAR: begin
            if (top_q >= DEPTH_C) begin
              fault_d = FAULT_OVF;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = top_q[AW-1:0];
              ram_wdata = (cmd_q == CMD_PUSH) ? {11'd0, bsize_q} : inval_q;
              top_d     = top_q + ONE_C;
            end
          end
          CMD_POP: begin
            if (top_q >= ONE_C) begin
              top_d = top_m1;
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_GREATER: begin
            if (top_q >= TWO_C) begin
              ram_we    = 1'b1;
              ram_waddr = top_m2[AW-1:0];
              case (cmd_q)
                CMD_ADD: ram_wdata = b_q + a_q;
                CMD_SUB: ram_wdata = b_q - a_q;
                CMD_MUL: ram_wdata = 32'(b_q * a_q);
                default: ram_wdata = {31'd0, $signed(b_q) > $signed(a_q)};
              endcase
              top_d = top_m1;
            end
          end
          CMD_DIV, CMD_MOD: begin
            if (top_q >= TWO_C) begin
              if (a_q == 32'd0) begin
                fault_d = FAULT_DIV0;
              end else begin
                rem_d   = 32'd0;
                quo_d   = mag_b;
                dvs_d   = mag_a;
                dcnt_d  = 5'd0;
                state_d = ST_DIV;
              end
            end
          end
          CMD_NOT: begin
            if (top_q >= ONE_C) begin
              ram_we    = 1'b1;
              ram_waddr = top_m1[AW-1:0];
              ram_wdata = {31'd0, a_q == 32'd0};
            end
          end
          CMD_POINTER: begin
            if (top_q >= ONE_C) begin
              top_d = top_m1;
              if (!a_q[31] && a_q != 32'd0) begin
                dir_d = dir_q + a_q[1:0];
              end
            end
          end
          CMD_SWITCH: begin
            if (top_q >= ONE_C) begin
              top_d = top_m1;
              if (!a_q[31] && a_q[0]) begin
                edge_d = ~edge_q;
              end
            end
          end
          CMD_DUP: begin
            if (top_q >= ONE_C) begin
              if (top_q >= DEPTH_C) begin
                fault_d = FAULT_OVF;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = top_q[AW-1:0];
                ram_wdata = a_q;
                top_d     = top_q + ONE_C;
              end
            end
          end
          CMD_ROLL: begin
            // a holds the count, b the depth.
            if (top_q >= TWO_C && !($signed({b_q[31], b_q}) > $signed(33'(top_m2)))) begin
              top_d = top_m2;
              if (!b_q[31] && b_q != 32'd0 && !a_q[31] && a_q != 32'd0) begin
                roll_d  = 1'b1;
                len_d   = roll_len;
                base_d  = top_m2 - roll_len;
                rem_d   = 32'd0;
                quo_d   = a_q;
                dvs_d   = b_q;
                dcnt_d  = 5'd0;
                state_d = ST_DIV;
              end
            end
          end
          CMD_OUT_NUM, CMD_OUT_CHAR: begin
            if (top_q >= ONE_C) begin
              top_d  = top_m1;
              kind_d = (cmd_q == CMD_OUT_NUM) ? KIND_NUM : KIND_CHAR;
              oval_d = (cmd_q == CMD_OUT_NUM) ? a_q : {24'd0, a_q[7:0]};
            end
          end
          default: begin
          end
        endcase
      end

      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = 32'(rem_sh - {1'b0, dvs_q});
          quo_d = quo_sh | 32'd1;
        end else begin
          rem_d = rem_sh[31:0];
          quo_d = quo_sh;
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = ST_DIV_END;
        end
      end

      ST_DIV_END: begin
        if (roll_q) begin
          k_d     = rem_q[CNTW-1:0];
          phase_d = 2'd0;
          lo_d    = base_q;
          hi_d    = base_q + len_q;
          state_d = ST_RV_CHECK;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = top_m2[AW-1:0];
          ram_wdata = (cmd_q == CMD_DIV) ? q_signed : r_signed;
          top_d     = top_m1;
          state_d   = ST_DONE;
        end
      end

      ST_RV_CHECK: begin
        // hi is one past the last entry of the range being reversed.
        if (lo_q + ONE_C < hi_q) begin
          state_d = ST_SW_RD_LO;
        end else begin
          case (phase_q)
            2'd0: begin
              phase_d = 2'd1;
              lo_d    = base_q;
              hi_d    = base_q + k_q;
            end
            2'd1: begin
              phase_d = 2'd2;
              lo_d    = base_q + k_q;
              hi_d    = base_q + len_q;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SW_RD_LO: begin
        ram_raddr = lo_q[AW-1:0];
        state_d   = ST_SW_RD_HI;
      end

      ST_SW_RD_HI: begin
        swap_d    = ram_rdata;
        ram_raddr = hi_m1[AW-1:0];
        state_d   = ST_SW_WR_LO;
      end

      ST_SW_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = ram_rdata;
        state_d   = ST_SW_WR_HI;
      end

      ST_SW_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_m1[AW-1:0];
        ram_wdata = swap_q;
        lo_d      = lo_q + ONE_C;
        hi_d      = hi_m1;
        state_d   = ST_RV_CHECK;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.out_kind    = kind_q;
          out_d.out_value   = oval_q;
          out_d.pointer_dir = dir_q;
          out_d.edge_choice = edge_q;
          out_d.stack_count = 7'(top_q);
          out_d.fault       = fault_q;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `PSCU_NEVER(a_top_bound, top_q > DEPTH_C, "stack count beyond depth")
  `PSCU_ASSERT(a_accept_fetch, in_accept |=> state_q == ST_FETCH_A, "accepted beat not fetched")
  `PSCU_ASSERT(a_div0_cmd, (state_q == ST_DONE && fault_q == FAULT_DIV0) |-> (cmd_q == CMD_DIV || cmd_q == CMD_MOD), "divide fault on non-divide command")
  `PSCU_ASSERT(a_swap_order, (state_q == ST_SW_RD_LO || state_q == ST_SW_WR_HI) |-> (lo_q + ONE_C < hi_q), "swap with crossed pointers")

endmodule

### rtl/pscu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pscu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piet stack command unit testbench
// Drives colour transitions in random bursts, stalls the result side on its
// own pattern and checks every result beat against a stack machine model.
// ----------------------------------------------------------------------------
module tb_top;
  import pscu_pkg::*;

  class piet_scoreboard;
    logic [31:0] vstack [64];
    int unsigned depth_used;
    logic [1:0]  dir_q;
    logic        edge_q;
    out_t        pending_q [$];
    int          mismatches;
    int          failures;

    function new();
      depth_used = 0;
      dir_q      = 2'd0;
      edge_q     = 1'b0;
      mismatches = 0;
      failures   = 0;
    endfunction

    function automatic cmd_e decode(logic [4:0] pc, logic [4:0] nc);
      int oc;
      int ncv;
      int dh;
      int dl;
      oc  = (pc > 17) ? 0 : pc;
      ncv = (nc > 17) ? 0 : nc;
      dh  = ((ncv % 6) + 6 - (oc % 6)) % 6;
      dl  = ((ncv / 6) + 3 - (oc / 6)) % 3;
      return cmd_e'(dh * 3 + dl);
    endfunction

    function automatic bit push_word(logic [31:0] v);
      if (depth_used >= 64) return 1'b0;
      vstack[depth_used] = v;
      depth_used++;
      return 1'b1;
    endfunction

    // Works out the result of one accepted beat and queues it.
    function void note_command(in_t it);
      out_t        r;
      cmd_e        c;
      logic [31:0] a;
      logic [31:0] b;
      longint      sa;
      longint      sb;
      longint      cnt;
      longint      dep;
      int          d;
      int          k;
      int          base;
      logic [31:0] tmp [64];
      r = '0;
      r.out_kind = KIND_NONE;
      r.fault    = FAULT_NONE;
      c = decode(it.prev_colour, it.new_colour);
      case (c)
        CMD_PUSH: if (!push_word({11'd0, it.block_size})) r.fault = FAULT_OVF;
        CMD_POP: if (depth_used >= 1) depth_used--;
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_GREATER: begin
          if (depth_used >= 2) begin
            a  = vstack[depth_used-1];
            b  = vstack[depth_used-2];
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            if ((c == CMD_DIV || c == CMD_MOD) && a == 32'd0) begin
              r.fault = FAULT_DIV0;
            end else begin
              case (c)
                CMD_ADD: b = b + a;
                CMD_SUB: b = b - a;
                CMD_MUL: b = b * a;
                CMD_DIV: b = 32'(sb / sa);
                CMD_MOD: b = 32'(sb % sa);
                default: b = (sb > sa) ? 32'd1 : 32'd0;
              endcase
              depth_used--;
              vstack[depth_used-1] = b;
            end
          end
        end
        CMD_NOT: begin
          if (depth_used >= 1)
            vstack[depth_used-1] = (vstack[depth_used-1] == 32'd0) ? 32'd1 : 32'd0;
        end
        CMD_POINTER: begin
          if (depth_used >= 1) begin
            depth_used--;
            sa = longint'($signed(vstack[depth_used]));
            if (sa > 0) dir_q = dir_q + 2'(sa);
          end
        end
        CMD_SWITCH: begin
          if (depth_used >= 1) begin
            depth_used--;
            sa = longint'($signed(vstack[depth_used]));
            if (sa > 0 && sa[0]) edge_q = ~edge_q;
          end
        end
        CMD_DUP: begin
          if (depth_used >= 1)
            if (!push_word(vstack[depth_used-1])) r.fault = FAULT_OVF;
        end
        CMD_ROLL: begin
          if (depth_used >= 2) begin
            cnt = longint'($signed(vstack[depth_used-1]));
            dep = longint'($signed(vstack[depth_used-2]));
            if (dep <= longint'(depth_used - 2)) begin
              depth_used -= 2;
              if (dep > 0 && cnt > 0) begin
                d    = int'(dep);
                k    = int'(cnt % dep);
                base = depth_used - d;
                for (int i = 0; i < d; i++) tmp[(i + k) % d] = vstack[base + i];
                for (int i = 0; i < d; i++) vstack[base + i] = tmp[i];
              end
            end
          end
        end
        CMD_IN_NUM, CMD_IN_CHAR: if (!push_word(it.in_value)) r.fault = FAULT_OVF;
        CMD_OUT_NUM, CMD_OUT_CHAR: begin
          if (depth_used >= 1) begin
            depth_used--;
            r.out_kind  = (c == CMD_OUT_NUM) ? KIND_NUM : KIND_CHAR;
            r.out_value = (c == CMD_OUT_NUM) ? vstack[depth_used]
                                             : {24'd0, vstack[depth_used][7:0]};
          end
        end
        default: ;
      endcase
      r.pointer_dir = dir_q;
      r.edge_choice = edge_q;
      r.stack_count = 7'(depth_used);
      pending_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending_q.size() == 0) begin
        failures++;
        $display("result beat with nothing expected: %p", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got !== exp_r) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  piet_scoreboard sb;
  int stall_mode;

  piet_stack_command_unit_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // The result side switches between free running, light and heavy stalling.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function automatic in_t make_beat(cmd_e c, logic [31:0] val, logic [20:0] bsz);
    in_t it;
    int  pc;
    int  dh;
    int  dl;
    pc = $urandom_range(0, 17);
    dh = int'(c) / 3;
    dl = int'(c) % 3;
    it.prev_colour = 5'(pc);
    it.new_colour  = 5'((((pc / 6) + dl) % 3) * 6 + ((pc % 6) + dh) % 6);
    it.block_size  = bsz;
    it.in_value    = val;
    return it;
  endfunction

  task automatic send_beat(in_t it);
    in_valid_i = 1'b1;
    in_data_i  = it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_command(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_cmd(cmd_e c, logic [31:0] val);
    send_beat(make_beat(c, val, 21'($urandom_range(0, 1048576))));
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r < 4) return 32'($urandom_range(0, 13) - 3);
    if (r == 4) return (($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff);
    return $urandom;
  endfunction

  initial begin
    in_t it;
    int  burst;
    int  r;
    int  fill;
    sb          = new();
    stall_mode  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, wrap, divide corner cases, empty stack behavior.
    send_cmd(CMD_OUT_NUM, 32'd0);
    send_cmd(CMD_ADD, 32'd0);
    send_beat(make_beat(CMD_PUSH, 32'd0, 21'd1048576));
    send_beat(make_beat(CMD_PUSH, 32'd0, 21'd0));
    send_cmd(CMD_IN_NUM, 32'h8000_0000);
    send_cmd(CMD_IN_NUM, 32'hffff_ffff);
    send_cmd(CMD_DIV, 32'd0);
    send_cmd(CMD_IN_CHAR, 32'hffff_ffff);
    send_cmd(CMD_MOD, 32'd0);
    send_cmd(CMD_IN_NUM, 32'd0);
    send_cmd(CMD_DIV, 32'd0);
    send_cmd(CMD_MOD, 32'd0);
    send_cmd(CMD_IN_NUM, 32'h7fff_ffff);
    send_cmd(CMD_DUP, 32'd0);
    send_cmd(CMD_ADD, 32'd0);
    send_cmd(CMD_IN_NUM, 32'hffff_fff9);
    send_cmd(CMD_MUL, 32'd0);
    send_cmd(CMD_SUB, 32'd0);
    send_cmd(CMD_GREATER, 32'd0);
    send_cmd(CMD_NOT, 32'd0);
    send_cmd(CMD_IN_NUM, 32'd3);
    send_cmd(CMD_POINTER, 32'd0);
    send_cmd(CMD_IN_NUM, 32'd5);
    send_cmd(CMD_SWITCH, 32'd0);
    send_cmd(CMD_OUT_CHAR, 32'd0);
    send_beat('{prev_colour: 5'd31, new_colour: 5'd18, block_size: 21'd7,
                in_value: 32'd1});

    for (int n = 0; n < 1400; n++) begin
      if (n == 700) wait_drained();
      burst = $urandom_range(0, 3);
      if (burst == 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
      fill = (n >= 500 && n < 620) ? 85 : 30;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) begin
        it.prev_colour = 5'($urandom_range(0, 31));
        it.new_colour  = 5'($urandom_range(0, 31));
        it.block_size  = 21'($urandom_range(0, 1048576));
        it.in_value    = $urandom;
      end else if (r < fill) begin
        case ($urandom_range(0, 3))
          0: it = make_beat(CMD_PUSH, $urandom, 21'($urandom_range(0, 1048576)));
          1: it = make_beat(CMD_IN_NUM, pick_value(), 21'($urandom));
          2: it = make_beat(CMD_IN_CHAR, pick_value(), 21'($urandom));
          default: it = make_beat(CMD_DUP, $urandom, 21'($urandom));
        endcase
      end else begin
        it = make_beat(cmd_e'($urandom_range(0, 17)), pick_value(), 21'($urandom));
      end
      if (it.block_size > 21'd1048576) it.block_size = 21'd1048576;
      send_beat(it);
    end

    wait_drained();
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/pscu_pkg.sv
rtl/pscu_ram.sv
rtl/piet_stack_command_unit_top.sv
sim/tb_top.sv
